>>> src/smf_pkg.sv
package smf_pkg;

    localparam int MAX_SIDE     = 512;
    localparam int MAX_RADIUS   = 15;
    localparam int VALUE_BITS   = 8;
    localparam int WIN_MAX      = 2 * MAX_RADIUS + 1;
    localparam int VALUE_COUNT  = 1 << VALUE_BITS;
    localparam int SIDE_BITS    = $clog2(MAX_SIDE + 1);
    localparam int COL_BITS     = $clog2(MAX_SIDE);
    localparam int RAD_BITS     = $clog2(MAX_RADIUS + 1);
    localparam int SLOT_BITS    = $clog2(WIN_MAX);
    localparam int COUNT_BITS   = $clog2(WIN_MAX * WIN_MAX + 1);
    localparam int SCAN_BITS    = VALUE_BITS + 1;
    localparam int LS_DEPTH     = WIN_MAX * MAX_SIDE;
    localparam int LS_ADDR_BITS = SLOT_BITS + COL_BITS;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = SIDE_BITS;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_SIDE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_RADIUS = 2'd1;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    // line store access
    typedef struct packed {
        logic                    wr_en;
        logic [LS_ADDR_BITS-1:0] wr_addr;
        value_t                  wr_data;
        logic [LS_ADDR_BITS-1:0] rd_addr;
    } ls_ctl_t;

    // histogram access
    typedef struct packed {
        logic   wr_en;
        value_t wr_addr;
        count_t wr_data;
        value_t rd_addr;
    } hist_ctl_t;

endpackage

>>> src/smf_if.sv
interface smf_pixel_if;
    logic                  valid;
    logic                  ready;
    logic [smf_pkg::VALUE_BITS-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface smf_result_if;
    logic                  valid;
    logic                  ready;
    logic [smf_pkg::VALUE_BITS-1:0] median;
    logic                  row_last;
    logic                  frame_last;
    modport source (output valid, output median, output row_last, output frame_last,
                    input ready);
    modport sink (input valid, input median, input row_last, input frame_last,
                  output ready);
endinterface

interface smf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [smf_pkg::CFG_IDX_BITS-1:0]    index;
    logic [smf_pkg::CFG_DATA_BITS-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/smf_line_store.sv
module smf_line_store (
    input  logic                clk,
    input  smf_pkg::ls_ctl_t    ctl,
    output smf_pkg::value_t     rd_data
);

    smf_pkg::value_t mem [0:smf_pkg::LS_DEPTH-1];

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        rd_data <= mem[ctl.rd_addr];
    end

endmodule

>>> src/smf_histogram.sv
module smf_histogram (
    input  logic                clk,
    input  smf_pkg::hist_ctl_t  ctl,
    output smf_pkg::count_t     rd_data
);

    smf_pkg::count_t mem [0:smf_pkg::VALUE_COUNT-1];

    // counts start at zero only through the scan, which clears every bin it reads;
    // a clearing pass after reset brings them there first
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        rd_data <= mem[ctl.rd_addr];
    end

endmodule

>>> src/sliding_window_median_filter.sv
// Square-window median filter over a square image streamed in raster order, one
// pixel per item. For each pixel at which a full window of side 2*radius+1 ends,
// one result carries the window median, with row_last and frame_last marking the
// end of an output row and of the frame; border pixels give no result. A pixel
// that gives no result does not hold up the stream. A pixel that gives a result
// holds off the next pixel while every window sample goes through a
// read-modify-write of the histogram memory (line store read, bin read, bin
// write), then a scan over the 256 bins finds the median and zeroes the
// histogram, and the result is handed to the output register, later while an
// earlier result still waits there. After reset a clearing pass of the
// histogram runs before the first pixel is taken.
// Writing either register restarts the frame at row 0, column 0.
module sliding_window_median_filter (
    input  logic        clk,
    input  logic        rst_n,
    smf_pixel_if.sink   pixels,
    smf_result_if.source results,
    smf_cfg_if.sink     cfg
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ADD_RD = 3'd2;
    localparam logic [2:0] ST_ADD_HR = 3'd3;
    localparam logic [2:0] ST_ADD_WR = 3'd4;
    localparam logic [2:0] ST_SCAN   = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    localparam int CB = smf_pkg::COL_BITS;
    localparam int SB = smf_pkg::SIDE_BITS;
    localparam int LB = smf_pkg::SLOT_BITS;
    localparam int NB = smf_pkg::COUNT_BITS;
    localparam int VB = smf_pkg::VALUE_BITS;
    localparam int QB = smf_pkg::SCAN_BITS;

    logic [2:0]    state_reg, state_next;
    logic [SB-1:0] side_reg, side_next;
    logic [smf_pkg::RAD_BITS-1:0] radius_reg, radius_next;
    logic [CB-1:0] row_reg, row_next;
    logic [CB-1:0] col_reg, col_next;
    logic [LB-1:0] slot_reg, slot_next;
    logic [LB-1:0] it_slot_reg, it_slot_next;
    logic [CB-1:0] it_col_reg, it_col_next;
    logic [CB-1:0] base_col_reg, base_col_next;
    logic [CB-1:0] end_col_reg, end_col_next;
    logic [NB-1:0] need_reg, need_next;
    logic          rl_reg, rl_next;
    logic          fl_reg, fl_next;
    logic [VB-1:0] val_reg, val_next;
    logic [QB-1:0] scan_reg, scan_next;
    logic [NB-1:0] acc_reg, acc_next;
    logic          found_reg, found_next;
    logic [VB-1:0] med_reg, med_next;
    logic          ov_reg, ov_next;
    logic [VB-1:0] om_reg, om_next;
    logic          orl_reg, orl_next;
    logic          ofl_reg, ofl_next;

    smf_pkg::ls_ctl_t   ls_ctl;
    smf_pkg::hist_ctl_t h_ctl;
    smf_pkg::value_t    ls_rdata;
    smf_pkg::count_t    h_rdata;

    logic          pix_acc, cfg_acc;
    logic [LB-1:0] win_w, win_last;
    logic [LB-1:0] two_r;
    logic          win_ok;
    logic [2*LB:0] sq_sum;
    logic [NB:0]   acc_sum;
    logic [SB-1:0] col_inc, row_inc;
    logic [VB-1:0] scan_prev;

    smf_line_store u_ls (
        .clk     (clk),
        .ctl     (ls_ctl),
        .rd_data (ls_rdata)
    );

    smf_histogram u_hist (
        .clk     (clk),
        .ctl     (h_ctl),
        .rd_data (h_rdata)
    );

    // handshakes
    assign pixels.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = (state_reg == ST_IDLE) && !pixels.valid;
    assign pix_acc      = pixels.valid && pixels.ready;
    assign cfg_acc      = cfg.valid && cfg.ready;

    assign results.valid      = ov_reg;
    assign results.median     = om_reg;
    assign results.row_last   = orl_reg;
    assign results.frame_last = ofl_reg;

    // window geometry
    assign win_w    = {radius_reg, 1'b1};
    assign win_last = {radius_reg, 1'b0};
    assign two_r    = {radius_reg, 1'b0};
    assign win_ok   = (row_reg >= CB'(two_r)) && (col_reg >= CB'(two_r));
    assign sq_sum   = (2*LB+1)'(win_w) * (2*LB+1)'(win_w) + (2*LB+1)'(1);
    assign col_inc  = SB'(col_reg) + SB'(1);
    assign row_inc  = SB'(row_reg) + SB'(1);
    assign acc_sum  = (NB+1)'(acc_reg) + (NB+1)'(h_rdata);
    assign scan_prev = VB'(scan_reg - QB'(1));

    always_comb
    begin
        state_next    = state_reg;
        side_next     = side_reg;
        radius_next   = radius_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        slot_next     = slot_reg;
        it_slot_next  = it_slot_reg;
        it_col_next   = it_col_reg;
        base_col_next = base_col_reg;
        end_col_next  = end_col_reg;
        need_next     = need_reg;
        rl_next       = rl_reg;
        fl_next       = fl_reg;
        val_next      = val_reg;
        scan_next     = scan_reg;
        acc_next      = acc_reg;
        found_next    = found_reg;
        med_next      = med_reg;
        ov_next       = ov_reg;
        om_next       = om_reg;
        orl_next      = orl_reg;
        ofl_next      = ofl_reg;

        ls_ctl.wr_en   = 1'b0;
        ls_ctl.wr_addr = {slot_reg, col_reg};
        ls_ctl.wr_data = pixels.pixel;
        ls_ctl.rd_addr = {it_slot_reg, it_col_reg};
        h_ctl.wr_en    = 1'b0;
        h_ctl.wr_addr  = scan_prev;
        h_ctl.wr_data  = '0;
        h_ctl.rd_addr  = VB'(scan_reg);

        // output register drains independently
        if (ov_reg && results.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero every histogram bin once after reset
                h_ctl.wr_en   = 1'b1;
                h_ctl.wr_addr = VB'(scan_reg);
                scan_next     = scan_reg + QB'(1);
                if (scan_reg == QB'(smf_pkg::VALUE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cfg_acc)
                begin
                    if (cfg.index == smf_pkg::REG_IMAGE_SIDE)
                    begin
                        if (cfg.data == '0)
                            side_next = SB'(1);
                        else if (cfg.data > SB'(smf_pkg::MAX_SIDE))
                            side_next = SB'(smf_pkg::MAX_SIDE);
                        else
                            side_next = SB'(cfg.data);
                        row_next  = '0;
                        col_next  = '0;
                        slot_next = '0;
                    end
                    else if (cfg.index == smf_pkg::REG_WINDOW_RADIUS)
                    begin
                        radius_next = cfg.data[smf_pkg::RAD_BITS-1:0];
                        row_next    = '0;
                        col_next    = '0;
                        slot_next   = '0;
                    end
                end
                else if (pix_acc)
                begin
                    ls_ctl.wr_en = 1'b1;
                    // start a window pass
                    if (win_ok)
                    begin
                        base_col_next = col_reg - CB'(two_r);
                        it_col_next   = col_reg - CB'(two_r);
                        end_col_next  = col_reg;
                        it_slot_next  = '0;
                        need_next     = sq_sum[NB:1];
                        rl_next       = (col_inc == side_reg);
                        fl_next       = (col_inc == side_reg) && (row_inc == side_reg);
                        state_next    = ST_ADD_RD;
                    end
                    // advance raster position
                    if (col_inc >= side_reg)
                    begin
                        col_next = '0;
                        if (row_inc >= side_reg)
                        begin
                            row_next  = '0;
                            slot_next = '0;
                        end
                        else
                        begin
                            row_next  = CB'(row_inc);
                            slot_next = (slot_reg == win_last) ? '0 : slot_reg + LB'(1);
                        end
                    end
                    else
                    begin
                        col_next = CB'(col_inc);
                    end
                end
            end

            ST_ADD_RD:
            begin
                state_next = ST_ADD_HR;
            end

            ST_ADD_HR:
            begin
                h_ctl.rd_addr = ls_rdata;
                val_next      = ls_rdata;
                state_next    = ST_ADD_WR;
            end

            ST_ADD_WR:
            begin
                // bump the bin of this window sample
                h_ctl.wr_en   = 1'b1;
                h_ctl.wr_addr = val_reg;
                h_ctl.wr_data = h_rdata + NB'(1);
                state_next    = ST_ADD_RD;
                if (it_col_reg == end_col_reg)
                begin
                    it_col_next  = base_col_reg;
                    it_slot_next = it_slot_reg + LB'(1);
                    if (it_slot_reg == win_last)
                    begin
                        scan_next  = '0;
                        acc_next   = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    it_col_next = it_col_reg + CB'(1);
                end
            end

            ST_SCAN:
            begin
                // read bin k, accumulate and clear bin k-1
                scan_next = scan_reg + QB'(1);
                if (scan_reg != '0)
                begin
                    h_ctl.wr_en = 1'b1;
                    acc_next    = NB'(acc_sum);
                    if (!found_reg && (acc_sum >= (NB+1)'(need_reg)))
                    begin
                        found_next = 1'b1;
                        med_next   = scan_prev;
                    end
                end
                if (scan_reg == QB'(smf_pkg::VALUE_COUNT))
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!ov_reg || results.ready)
                begin
                    ov_next    = 1'b1;
                    om_next    = med_reg;
                    orl_next   = rl_reg;
                    ofl_next   = fl_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            side_reg   <= SB'(smf_pkg::MAX_SIDE);
            radius_reg <= smf_pkg::RAD_BITS'(1);
            row_reg    <= '0;
            col_reg    <= '0;
            slot_reg   <= '0;
            scan_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            side_reg   <= side_next;
            radius_reg <= radius_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            slot_reg   <= slot_next;
            scan_reg   <= scan_next;
            ov_reg     <= ov_next;
        end
    end

    // payload and iteration registers
    always_ff @(posedge clk)
    begin
        it_slot_reg  <= it_slot_next;
        it_col_reg   <= it_col_next;
        base_col_reg <= base_col_next;
        end_col_reg  <= end_col_next;
        need_reg     <= need_next;
        rl_reg       <= rl_next;
        fl_reg       <= fl_next;
        val_reg      <= val_next;
        acc_reg      <= acc_next;
        found_reg    <= found_next;
        med_reg      <= med_next;
        om_reg       <= om_next;
        orl_reg      <= orl_next;
        ofl_reg      <= ofl_next;
    end

endmodule

>>> test/smf_checker.sv
module smf_checker (
    input  logic   clk,
    input  logic   rst_n,
    smf_pixel_if   pixels,
    smf_result_if  results,
    smf_cfg_if     cfg,
    output int     failures,
    output int     pending_medians,
    output int     medians_seen
);

    typedef struct {
        smf_pkg::value_t median;
        logic            row_last;
        logic            frame_last;
    } median_rec_t;

    // own copy of the filter state
    smf_pkg::value_t                rows_kept [smf_pkg::WIN_MAX][smf_pkg::MAX_SIDE];
    logic [smf_pkg::SIDE_BITS-1:0]  side_reg;
    logic [smf_pkg::RAD_BITS-1:0]   radius_reg;
    int                             cur_row;
    int                             cur_col;
    median_rec_t                    expected_medians [$];

    // window median for the pixel just stored at row, col
    function automatic smf_pkg::value_t window_median(int row, int col, int w);
        int tally [smf_pkg::VALUE_COUNT];
        int need;
        int acc;
        int slot;
        for (int v = 0; v < smf_pkg::VALUE_COUNT; v++)
            tally[v] = 0;
        for (int dr = 0; dr < w; dr++)
        begin
            slot = (row - dr) % w;
            for (int dc = 0; dc < w; dc++)
                tally[rows_kept[slot][col - dc]]++;
        end
        need = (w * w + 1) / 2;
        acc = 0;
        for (int v = 0; v < smf_pkg::VALUE_COUNT; v++)
        begin
            acc += tally[v];
            if (acc >= need)
                return smf_pkg::value_t'(v);
        end
        return smf_pkg::value_t'(smf_pkg::VALUE_COUNT - 1);
    endfunction

    // take one pixel, queue the median it causes
    task automatic take_pixel(smf_pkg::value_t px);
        int          side;
        int          rad;
        int          w;
        median_rec_t rec;
        side = (side_reg == 0) ? 1 :
               (side_reg > smf_pkg::MAX_SIDE) ? smf_pkg::MAX_SIDE : int'(side_reg);
        rad  = (radius_reg > smf_pkg::MAX_RADIUS) ? smf_pkg::MAX_RADIUS : int'(radius_reg);
        w    = 2 * rad + 1;
        if (cur_row >= side || cur_col >= side)
        begin
            cur_row = 0;
            cur_col = 0;
        end
        rows_kept[cur_row % w][cur_col] = px;
        if (cur_row >= 2 * rad && cur_col >= 2 * rad)
        begin
            rec.median     = window_median(cur_row, cur_col, w);
            rec.row_last   = (cur_col == side - 1);
            rec.frame_last = (cur_col == side - 1) && (cur_row == side - 1);
            expected_medians.push_back(rec);
        end
        cur_col++;
        if (cur_col >= side)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= side)
                cur_row = 0;
        end
    endtask

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        median_rec_t want;
        if (!rst_n)
        begin
            side_reg        = 10'd512;
            radius_reg      = 4'd1;
            cur_row         = 0;
            cur_col         = 0;
            failures        = 0;
            medians_seen    = 0;
            expected_medians.delete();
            pending_medians = 0;
        end
        else
        begin
            // writes to either register restart the frame
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == smf_pkg::REG_IMAGE_SIDE)
                begin
                    side_reg = cfg.data;
                    cur_row  = 0;
                    cur_col  = 0;
                end
                else if (cfg.index == smf_pkg::REG_WINDOW_RADIUS)
                begin
                    radius_reg = cfg.data[smf_pkg::RAD_BITS-1:0];
                    cur_row    = 0;
                    cur_col    = 0;
                end
            end
            if (pixels.valid && pixels.ready)
                take_pixel(pixels.pixel);
            // compare medians in order
            if (results.valid && results.ready)
            begin
                medians_seen++;
                if (expected_medians.size() == 0)
                begin
                    $error("median with nothing expected: %0d", results.median);
                    failures++;
                end
                else
                begin
                    want = expected_medians.pop_front();
                    if (results.median !== want.median)
                    begin
                        $error("median: expected %0d, got %0d", want.median, results.median);
                        failures++;
                    end
                    if (results.row_last !== want.row_last)
                    begin
                        $error("row_last: expected %0d, got %0d", want.row_last,
                               results.row_last);
                        failures++;
                    end
                    if (results.frame_last !== want.frame_last)
                    begin
                        $error("frame_last: expected %0d, got %0d", want.frame_last,
                               results.frame_last);
                        failures++;
                    end
                end
            end
            pending_medians = expected_medians.size();
        end
    end

endmodule

>>> test/tb_top.sv
module tb_top;

    localparam int STALL_LIMIT = 40000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    smf_pixel_if  pix ();
    smf_result_if res ();
    smf_cfg_if    cfg_ch ();

    int  failures;
    int  pending_medians;
    int  medians_seen;
    int  pixels_sent;
    int  phases_run;
    int  quiet_cycles;
    bit  idle_on;
    bit  hold_request;
    bit  hold_done;

    always #2 clk = ~clk;

    sliding_window_median_filter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix),
        .results (res),
        .cfg     (cfg_ch)
    );

    smf_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixels          (pix),
        .results         (res),
        .cfg             (cfg_ch),
        .failures        (failures),
        .pending_medians (pending_medians),
        .medians_seen    (medians_seen)
    );

    // known values from time zero
    initial
    begin
        pix.valid    = 1'b0;
        pix.pixel    = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = smf_pkg::REG_IMAGE_SIDE;
        cfg_ch.data  = '0;
        res.ready    = 1'b0;
    end

    // result receiver with random stalls and one long hold-off
    initial
    begin
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                res.ready <= 1'b0;
                repeat (900) @(posedge clk);
                hold_done = 1'b1;
                res.ready <= 1'b1;
            end
            else
                res.ready <= !(idle_on && $urandom_range(99) < 16);
        end
    end

    // watchdog on handshakes
    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("sliding_window_median_filter test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [smf_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [smf_pkg::CFG_DATA_BITS-1:0] val);
        // no pixel is offered while a register is written
        pix.valid <= 1'b0;
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        forever
        begin
            @(negedge clk);
            if (cfg_ch.ready)
                break;
        end
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // offer one pixel, return after the edge that takes it
    task automatic send_pixel(smf_pkg::value_t px);
        if (idle_on && $urandom_range(99) < 16)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.pixel <= px;
        forever
        begin
            @(negedge clk);
            if (pix.ready)
                break;
        end
        @(posedge clk);
        pixels_sent++;
    endtask

    // wait until every median is back and the block is quiet
    task automatic drain();
        pix.valid <= 1'b0;
        repeat (3) @(posedge clk);
        while (pending_medians != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic smf_pkg::value_t pick_pixel();
        case ($urandom_range(3))
            0: return smf_pkg::value_t'($urandom_range(0, 3) * 85);
            1: return smf_pkg::value_t'($urandom_range(0, 3));
            default: return smf_pkg::value_t'($urandom);
        endcase
    endfunction

    task automatic run_frame(logic [smf_pkg::CFG_DATA_BITS-1:0] side_val,
                             logic [smf_pkg::CFG_DATA_BITS-1:0] rad_val, int count);
        drain();
        write_reg(smf_pkg::REG_IMAGE_SIDE, side_val);
        write_reg(smf_pkg::REG_WINDOW_RADIUS, rad_val);
        for (int i = 0; i < count; i++)
            send_pixel(pick_pixel());
        phases_run++;
    endtask

    initial
    begin
        int side;
        int rad;
        pixels_sent = 0;
        phases_run  = 0;
        idle_on     = 1'b0;
        hold_request = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings first, then extreme pixels on a 3x3 window
        for (int i = 0; i < 4; i++)
            send_pixel(i[0] ? 8'hFF : 8'h00);
        drain();
        write_reg(smf_pkg::REG_IMAGE_SIDE, 10'd3);
        write_reg(smf_pkg::REG_WINDOW_RADIUS, 10'd1);
        send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h00);
        send_pixel(8'hFF); send_pixel(8'h80); send_pixel(8'hFF);
        send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h7F);
        // frame wraps into the next one
        send_pixel(8'hAA); send_pixel(8'h55);
        // unused register indexes leave the frame running
        write_reg(2'd2, 10'h3FF);
        write_reg(2'd3, 10'h155);
        for (int i = 0; i < 7; i++)
            send_pixel(pick_pixel());
        run_frame(10'd0, 10'd0, 3);         // side zero acts as one
        run_frame(10'd2, 10'd1, 6);         // image smaller than window
        run_frame(10'd1023, 10'h3F0, 12);   // side above the maximum, radius zero
        run_frame(10'd5, 10'd2, 25);
        run_frame(10'd512, 10'd1, 20);
        run_frame(10'd31, 10'd15, 31 * 31); // largest window

        // receiver holds off while the sender keeps offering
        hold_request = 1'b1;
        run_frame(10'd8, 10'd1, 64);

        // random settings, small frames
        while (pixels_sent < 1200)
        begin
            idle_on = (phases_run % 5) != 0;
            case ($urandom_range(9))
                0: begin side = $urandom_range(1, 4); rad = $urandom_range(1, 3); end
                1: begin side = $urandom_range(3, 12); rad = 0; end
                default: begin rad = $urandom_range(1, 3); side = $urandom_range(2*rad+1, 12); end
            endcase
            run_frame(side[smf_pkg::CFG_DATA_BITS-1:0], rad[smf_pkg::CFG_DATA_BITS-1:0],
                      $urandom_range(side * side / 2, side * side + 2));
        end

        drain();
        $display("ran %0d pixels over %0d register settings, %0d medians checked",
                 pixels_sent, phases_run, medians_seen);
        $display("covered side and radius extremes, frame wrap, stalls on both sides");
        if (failures == 0)
            $display("sliding_window_median_filter test passed");
        else
            $display("sliding_window_median_filter test failed");
        $finish;
    end

endmodule
